>>> hw/rtl/hcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hcr_pkg;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_DISCARD = 2'd3;

    localparam logic [1:0] MODE_CHAIN  = 2'd0;
    localparam logic [1:0] MODE_QUAD   = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;
    localparam logic [1:0] MODE_LINEAR = 2'd3;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_SIZE = 1'b1;

    localparam int CFG_W    = 10;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 56;
    localparam int VAL_IO_W = 16;
    localparam int IDX_W    = 10;
    localparam int COUNT_W  = 16;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_KEY_CLEAR,
        DP_MOD_INIT,
        DP_MOD_STEP,
        DP_PROBE_INIT,
        DP_READ,
        DP_ADVANCE,
        DP_CMP_READ,
        DP_CMP_NEXT,
        DP_STORE,
        DP_COPY_READ,
        DP_COPY_WRITE,
        DP_LINK_HEAD,
        DP_OVF_TAKE,
        DP_COLL,
        DP_CLR_STEP,
        DP_RESULT
    } dp_op_t;

    typedef enum logic [2:0] {
        RES_HIT,
        RES_INSERT,
        RES_MISS,
        RES_FULL,
        RES_CLEAR
    } res_kind_t;

    typedef struct packed {
        dp_op_t    op;
        logic      link_old;
        res_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic       key_last;
        logic [1:0] op;
        logic       chain;
        logic       used;
        logic       len_eq;
        logic       byte_eq;
        logic       byte_last;
        logic       more;
        logic       ovf_avail;
        logic       first_probe;
        logic       mod_done;
        logic       clr_last;
        logic       out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/hcr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module hcr_dp
    import hcr_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BYTES   = 36,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    input  wire logic [IN_W-1:0]   s_tdata,
    input  wire logic [1:0]        s_tuser,
    input  wire logic              s_tlast,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    localparam int SW        = $clog2(TABLE_SLOTS);
    localparam int HALF      = TABLE_SLOTS / 2;
    localparam int KLW       = $clog2(KEY_BYTES);
    localparam int SUMW      = $clog2(KEY_BYTES * 255);
    localparam int KEY_DEPTH = TABLE_SLOTS * KEY_BYTES;
    localparam int KAW       = $clog2(KEY_DEPTH);
    localparam int CW        = SW + 1;
    localparam int LW        = SW + 1;
    localparam int MCW       = $clog2(SUMW + 1);
    localparam logic [LW-1:0] LINK_NONE = {LW{1'b1}};

    logic                  used_mem [TABLE_SLOTS];
    logic [KLW-1:0]        len_mem  [TABLE_SLOTS];
    logic [VALUE_BITS-1:0] val_mem  [TABLE_SLOTS];
    logic [LW-1:0]         link_mem [TABLE_SLOTS];
    logic [7:0]            key_mem  [KEY_DEPTH];
    logic [7:0]            kbuf_mem [KEY_BYTES];

    logic [1:0]            mode_reg;
    logic [CFG_W-1:0]      size_reg;
    logic [KLW-1:0]        key_len_reg;
    logic [SUMW-1:0]       key_sum_reg;
    logic                  last_reg;
    logic [1:0]            op_reg;
    logic [VAL_IO_W-1:0]   value_reg;
    logic [SW-1:0]         ts_reg;
    logic [SUMW-1:0]       sum_sh_reg;
    logic [SW-1:0]         rem_reg;
    logic [MCW-1:0]        mod_cnt_reg;
    logic [SW-1:0]         cur_reg;
    logic [SW-1:0]         h_reg;
    logic [SW-1:0]         d_reg;
    logic [CW-1:0]         i_reg;
    logic [CW-1:0]         probe_reg;
    logic                  homec_reg;
    logic [KLW-1:0]        j_reg;
    logic [SW-1:0]         ovf_reg;
    logic [COUNT_W-1:0]    coll_reg;
    logic [SW-1:0]         clr_reg;
    logic [KAW-1:0]        base_reg;
    logic                  used_q;
    logic [KLW-1:0]        len_q;
    logic [VALUE_BITS-1:0] val_q;
    logic [LW-1:0]         link_q;
    logic [7:0]            kb_q;
    logic [7:0]            sk_q;
    logic                  m_valid_reg;
    logic [OUT_W-1:0]      m_data_reg;

    logic [SW-1:0]         ts_eff;
    logic [SW:0]           shifted;
    logic [SW-1:0]         rem_next;
    logic [SW-1:0]         cur_next;
    logic [SW-1:0]         d_next;
    logic                  link_ok;
    logic [KAW-1:0]        kaddr;
    logic [7:0]            in_byte;
    logic [IDX_W-1:0]      probes_sat;
    logic [OUT_W-1:0]      res_data;

    function automatic logic [SW-1:0] wrap(input logic [SW:0] v, input logic [SW:0] m);
        wrap = (v >= m) ? SW'(v - m) : SW'(v);
    endfunction

    assign in_byte = s_tdata[7:0];
    assign kaddr   = base_reg + KAW'(j_reg);
    assign link_ok = link_q < LW'(TABLE_SLOTS);

    always_comb begin
        if (size_reg < CFG_W'(2)) begin
            ts_eff = SW'(2);
        end else if (32'(size_reg) > 32'(HALF)) begin
            ts_eff = SW'(HALF);
        end else begin
            ts_eff = SW'(size_reg);
        end
    end

    assign shifted  = {rem_reg, sum_sh_reg[SUMW-1]};
    assign rem_next = wrap(shifted, {1'b0, ts_reg});

    always_comb begin
        d_next = d_reg;
        unique case (mode_reg)
            MODE_CHAIN:  cur_next = SW'(link_q);
            MODE_QUAD: begin
                cur_next = wrap({1'b0, cur_reg} + {1'b0, d_reg}, {1'b0, ts_reg});
                d_next   = wrap({1'b0, d_reg} + (SW+1)'(2), {1'b0, ts_reg});
            end
            MODE_DOUBLE: cur_next = wrap({cur_reg, 1'b1}, {1'b0, ts_reg});
            default:     cur_next = wrap({1'b0, cur_reg} + (SW+1)'(1), {1'b0, ts_reg});
        endcase
    end

    always_comb begin
        status.key_last    = last_reg;
        status.op          = op_reg;
        status.chain       = mode_reg == MODE_CHAIN;
        status.used        = used_q;
        status.len_eq      = len_q == key_len_reg;
        status.byte_eq     = kb_q == sk_q;
        status.byte_last   = j_reg == key_len_reg - KLW'(1);
        status.more        = (mode_reg == MODE_CHAIN) ?
                             (link_ok && i_reg < CW'(TABLE_SLOTS)) : (i_reg < {1'b0, ts_reg});
        status.ovf_avail   = ovf_reg < ts_reg;
        status.first_probe = i_reg == CW'(1);
        status.mod_done    = mod_cnt_reg == MCW'(SUMW);
        status.clr_last    = clr_reg == SW'(TABLE_SLOTS - 1);
        status.out_free    = !m_valid_reg || m_tready;
    end

    assign probes_sat = (32'(probe_reg) > 32'd1023) ? IDX_W'(1023) : IDX_W'(probe_reg);

    always_comb begin
        logic               found;
        logic [VAL_IO_W-1:0] rval;
        logic [IDX_W-1:0]   sidx;
        logic [IDX_W-1:0]   prb;
        logic               hc;
        found = (cmd.kind == RES_HIT) || (cmd.kind == RES_INSERT);
        rval  = (cmd.kind == RES_HIT) ? VAL_IO_W'(val_q) : '0;
        sidx  = found ? IDX_W'(cur_reg) : '0;
        prb   = (cmd.kind == RES_CLEAR) ? '0 : probes_sat;
        hc    = (cmd.kind == RES_CLEAR) ? 1'b0 : homec_reg;
        res_data = {1'b0, coll_reg, cmd.kind == RES_FULL, hc, prb, sidx, rval, found};
    end

    // slot memories
    always_ff @(posedge aclk) begin
        if (cmd.op == DP_CLR_STEP) begin
            used_mem[clr_reg] <= 1'b0;
        end else if (cmd.op == DP_STORE) begin
            used_mem[cur_reg] <= 1'b1;
        end
        if (cmd.op == DP_READ) begin
            used_q <= used_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_STORE) begin
            len_mem[cur_reg] <= key_len_reg;
            val_mem[cur_reg] <= VALUE_BITS'(value_reg);
        end
        if (cmd.op == DP_READ) begin
            len_q <= len_mem[cur_reg];
            val_q <= val_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_STORE) begin
            link_mem[cur_reg] <= cmd.link_old ? link_q : LINK_NONE;
        end else if (cmd.op == DP_LINK_HEAD) begin
            link_mem[h_reg] <= {1'b0, cur_reg};
        end
        if (cmd.op == DP_READ) begin
            link_q <= link_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_COPY_WRITE) begin
            key_mem[kaddr] <= kb_q;
        end
        if (cmd.op == DP_CMP_READ) begin
            sk_q <= key_mem[kaddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == DP_ACCEPT && 32'(key_len_reg) < KEY_BYTES - 1) begin
            kbuf_mem[key_len_reg] <= in_byte;
        end
        if (cmd.op == DP_CMP_READ || cmd.op == DP_COPY_READ) begin
            kb_q <= kbuf_mem[j_reg];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        base_reg <= KAW'(cur_reg) * KAW'(KEY_BYTES);
        unique case (cmd.op)
            DP_ACCEPT:     value_reg <= s_tdata[IN_W-1:8];
            DP_MOD_INIT: begin
                ts_reg     <= ts_eff;
                sum_sh_reg <= key_sum_reg;
                rem_reg    <= '0;
            end
            DP_MOD_STEP: begin
                rem_reg    <= rem_next;
                sum_sh_reg <= {sum_sh_reg[SUMW-2:0], 1'b0};
            end
            DP_PROBE_INIT: begin
                cur_reg <= rem_reg;
                h_reg   <= rem_reg;
                d_reg   <= SW'(1);
            end
            DP_ADVANCE: begin
                cur_reg <= cur_next;
                d_reg   <= d_next;
            end
            DP_OVF_TAKE:   cur_reg <= ts_reg + ovf_reg;
            DP_RESULT:     m_data_reg <= res_data;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_LINEAR;
            size_reg    <= CFG_W'(509);
            key_len_reg <= '0;
            key_sum_reg <= '0;
            last_reg    <= 1'b0;
            op_reg      <= OP_INSERT;
            mod_cnt_reg <= '0;
            i_reg       <= '0;
            probe_reg   <= '0;
            homec_reg   <= 1'b0;
            j_reg       <= '0;
            ovf_reg     <= '0;
            coll_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MODE) begin
                    mode_reg <= cfg_wdata[1:0];
                end else begin
                    size_reg <= cfg_wdata;
                end
            end
            if (cmd.op == DP_RESULT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                DP_ACCEPT: begin
                    last_reg <= s_tlast;
                    op_reg   <= s_tuser;
                    if (32'(key_len_reg) < KEY_BYTES - 1) begin
                        key_len_reg <= key_len_reg + KLW'(1);
                        key_sum_reg <= key_sum_reg + SUMW'(in_byte);
                    end
                end
                DP_KEY_CLEAR: begin
                    key_len_reg <= '0;
                    key_sum_reg <= '0;
                end
                DP_MOD_INIT:   mod_cnt_reg <= '0;
                DP_MOD_STEP:   mod_cnt_reg <= mod_cnt_reg + MCW'(1);
                DP_PROBE_INIT: begin
                    i_reg     <= '0;
                    probe_reg <= '0;
                    homec_reg <= 1'b0;
                end
                DP_READ: begin
                    i_reg     <= i_reg + CW'(1);
                    probe_reg <= probe_reg + CW'(1);
                    j_reg     <= '0;
                end
                DP_CMP_NEXT:   j_reg <= j_reg + KLW'(1);
                DP_STORE:      j_reg <= '0;
                DP_COPY_WRITE: j_reg <= j_reg + KLW'(1);
                DP_OVF_TAKE:   ovf_reg <= ovf_reg + SW'(1);
                DP_COLL: begin
                    homec_reg <= 1'b1;
                    if (coll_reg != {COUNT_W{1'b1}}) begin
                        coll_reg <= coll_reg + COUNT_W'(1);
                    end
                end
                DP_CLR_STEP: begin
                    clr_reg <= status.clr_last ? '0 : clr_reg + SW'(1);
                    ovf_reg <= '0;
                end
                DP_RESULT: begin
                    key_len_reg <= '0;
                    key_sum_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/hcr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module hcr_ctrl
    import hcr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_PROBE_INIT,
        ST_READ,
        ST_CHECK,
        ST_ADVANCE,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_OVF,
        ST_STORE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_LINK,
        ST_RESULT
    } state_t;

    state_t    state_reg, state_next;
    logic      chain_reg, chain_next;
    logic      clr_report_reg, clr_report_next;
    res_kind_t kind_reg, kind_next;

    always_comb begin
        state_next      = state_reg;
        chain_next      = chain_reg;
        clr_report_next = clr_report_reg;
        kind_next       = kind_reg;
        cmd.op          = DP_NOP;
        cmd.link_old    = chain_reg;
        cmd.kind        = kind_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.op = DP_CLR_STEP;
                if (status.clr_last) begin
                    kind_next  = RES_CLEAR;
                    state_next = clr_report_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = DP_ACCEPT;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.key_last) begin
                    state_next = ST_IDLE;
                end else if (status.op == OP_DISCARD) begin
                    cmd.op     = DP_KEY_CLEAR;
                    state_next = ST_IDLE;
                end else if (status.op == OP_CLEAR) begin
                    clr_report_next = 1'b1;
                    state_next      = ST_CLEAR;
                end else begin
                    cmd.op     = DP_MOD_INIT;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (status.mod_done) begin
                    state_next = ST_PROBE_INIT;
                end else begin
                    cmd.op = DP_MOD_STEP;
                end
            end
            ST_PROBE_INIT: begin
                cmd.op     = DP_PROBE_INIT;
                chain_next = 1'b0;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.op     = DP_READ;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.op == OP_INSERT) begin
                    if (status.used && status.first_probe) begin
                        cmd.op = DP_COLL;
                    end
                    if (!status.used) begin
                        state_next = ST_STORE;
                    end else if (status.chain ? status.ovf_avail : status.more) begin
                        state_next = status.chain ? ST_OVF : ST_ADVANCE;
                    end else begin
                        kind_next  = RES_FULL;
                        state_next = ST_RESULT;
                    end
                end else if (status.used && status.len_eq) begin
                    state_next = ST_CMP_RD;
                end else if (status.used && status.more) begin
                    state_next = ST_ADVANCE;
                end else begin
                    kind_next  = RES_MISS;
                    state_next = ST_RESULT;
                end
            end
            ST_ADVANCE: begin
                cmd.op     = DP_ADVANCE;
                state_next = ST_READ;
            end
            ST_CMP_RD: begin
                cmd.op     = DP_CMP_READ;
                state_next = ST_CMP_CHK;
            end
            ST_CMP_CHK: begin
                if (!status.byte_eq) begin
                    kind_next  = RES_MISS;
                    state_next = status.more ? ST_ADVANCE : ST_RESULT;
                end else if (status.byte_last) begin
                    kind_next  = RES_HIT;
                    state_next = ST_RESULT;
                end else begin
                    cmd.op     = DP_CMP_NEXT;
                    state_next = ST_CMP_RD;
                end
            end
            ST_OVF: begin
                cmd.op     = DP_OVF_TAKE;
                chain_next = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                cmd.op     = DP_STORE;
                state_next = ST_COPY_RD;
            end
            ST_COPY_RD: begin
                cmd.op     = DP_COPY_READ;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                cmd.op = DP_COPY_WRITE;
                if (status.byte_last) begin
                    kind_next  = RES_INSERT;
                    state_next = chain_reg ? ST_LINK : ST_RESULT;
                end else begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_LINK: begin
                cmd.op     = DP_LINK_HEAD;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.op          = DP_RESULT;
                    clr_report_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            chain_reg      <= 1'b0;
            clr_report_reg <= 1'b0;
            kind_reg       <= RES_MISS;
        end else begin
            state_reg      <= state_next;
            chain_reg      <= chain_next;
            clr_report_reg <= clr_report_next;
            kind_reg       <= kind_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule
`default_nettype wire

>>> hw/rtl/hash_table_collision_resolver.sv
// Channel  Dir  Handshake        Payload
// s_       in   s_tvalid/tready  tdata: key_byte, value_handle; tuser: operation; tlast: key_last
// m_       out  m_tvalid/tready  tdata: found .. collision_total (one item per insert, lookup or clear command)
// cfg_     in   cfg_wr_en        cfg_index, cfg_wdata
//
// Each key byte is accepted and then decoded before the next byte is taken. A command item
// then goes through hashing and setup (one remainder bit per cycle), a read and a check per
// slot visited plus an advance step to the next slot, and a read and a compare or write per
// key byte compared or stored, all through single-port slot memories.
// After reset and on a clear command, a sweep clears every slot-used memory entry
// while no item is accepted. A stalled result sits in the output register; the
// next key's bytes are still taken.
`timescale 1ns / 1ps
`default_nettype none
module hash_table_collision_resolver
    import hcr_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BYTES   = 36,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // key_byte[7:0], value_handle[23:8]
    input  wire logic [1:0]       s_tuser,   // operation[1:0]
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // found[0], result_value[16:1],
                                             // slot_index[26:17], probe_count[36:27],
                                             // home_collision[37], table_full[38],
                                             // collision_total[54:39]
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    hcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hcr_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BYTES   (KEY_BYTES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_result_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_RESULT |-> status.out_free)
        else $error("result loaded into a full output register");

    a_sweep_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input taken before the clearing sweep");

    a_advance_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_ADVANCE |=> cmd.op == DP_READ)
        else $error("advance not followed by slot read");

    a_decode_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken without decode cycle");

endmodule
`default_nettype wire

>>> verif/hash_table_checker.sv
`timescale 1ns / 1ps
module hash_table_checker
    import hcr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic [1:0]       s_tuser,
    input  wire logic             s_tlast,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    output int                    pending,
    output int                    errors
);
    localparam int SLOTS = 1024;
    localparam int KMAX  = 36;

    typedef struct packed {
        logic        found;
        logic [15:0] value;
        logic [9:0]  slot;
        logic [9:0]  probes;
        logic        home_coll;
        logic        full;
        logic [15:0] coll_total;
    } lookup_result_t;

    lookup_result_t expected_results[$];

    logic [1:0]  mode;
    logic [9:0]  tsize;
    logic [7:0]  kbuf[KMAX];
    int          klen, ksum, ovf_next, coll_cnt;
    bit          used[SLOTS];
    logic [7:0]  skey[SLOTS][KMAX];
    int          slen[SLOTS];
    logic [15:0] sval[SLOTS];
    int          slink[SLOTS];

    assign pending = expected_results.size();

    function automatic int eff_size();
        int s;
        s = tsize;
        if (s < 2) s = 2;
        if (s > SLOTS / 2) s = SLOTS / 2;
        return s;
    endfunction

    function automatic bit key_equal(int slot);
        if (slen[slot] != klen) return 0;
        for (int i = 0; i < klen; i++)
            if (skey[slot][i] != kbuf[i]) return 0;
        return 1;
    endfunction

    function automatic void store_entry(int slot, logic [15:0] v);
        used[slot] = 1'b1;
        for (int i = 0; i < klen; i++) skey[slot][i] = kbuf[i];
        slen[slot] = klen;
        sval[slot] = v;
        slink[slot] = -1;
    endfunction

    function automatic int next_probe(int h, int prev, int m, int ts);
        if (m == 0) return h;
        if (mode == MODE_QUAD) return (h + m * m) % ts;
        if (mode == MODE_DOUBLE) return (prev * 2 + 1) % ts;
        return (h + m) % ts;
    endfunction

    task automatic hash_step(logic [1:0] op, logic [7:0] kb, logic last, logic [15:0] v);
        lookup_result_t r;
        int ts, h, cur, probes, s;
        r = '0;
        probes = 0;
        if (klen < KMAX - 1) begin
            kbuf[klen] = kb;
            klen++;
            ksum += kb;
        end
        if (!last) return;
        ts = eff_size();
        h = ksum % ts;
        if (op == OP_DISCARD) begin
            klen = 0;
            ksum = 0;
            return;
        end
        if (op == OP_CLEAR) begin
            for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
            ovf_next = 0;
        end else if (op == OP_INSERT) begin
            if (used[h]) begin
                r.home_coll = 1'b1;
                if (coll_cnt < 16'hFFFF) coll_cnt++;
            end
            if (mode == MODE_CHAIN) begin
                probes = 1;
                if (!used[h]) begin
                    store_entry(h, v);
                    r.found = 1'b1; r.slot = 10'(h);
                end else if (ovf_next < ts) begin
                    s = ts + ovf_next;
                    cur = slink[h];
                    store_entry(s, v);
                    slink[s] = cur;
                    slink[h] = s;
                    ovf_next++;
                    r.found = 1'b1; r.slot = 10'(s);
                end else begin
                    r.full = 1'b1;
                end
            end else begin
                cur = h;
                r.full = 1'b1;
                for (int i = 0; i < ts; i++) begin
                    cur = next_probe(h, cur, i, ts);
                    probes++;
                    if (!used[cur]) begin
                        store_entry(cur, v);
                        r.found = 1'b1; r.slot = 10'(cur); r.full = 1'b0;
                        break;
                    end
                end
            end
        end else begin
            cur = h;
            if (mode == MODE_CHAIN) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (cur < 0 || cur >= SLOTS) break;
                    probes++;
                    if (!used[cur]) break;
                    if (key_equal(cur)) begin
                        r.found = 1'b1; r.value = sval[cur]; r.slot = 10'(cur);
                        break;
                    end
                    cur = slink[cur];
                end
            end else begin
                for (int i = 0; i < ts; i++) begin
                    cur = next_probe(h, cur, i, ts);
                    probes++;
                    if (!used[cur]) break;
                    if (key_equal(cur)) begin
                        r.found = 1'b1; r.value = sval[cur]; r.slot = 10'(cur);
                        break;
                    end
                end
            end
        end
        klen = 0;
        ksum = 0;
        if (probes > 1023) probes = 1023;
        r.probes = 10'(probes);
        r.coll_total = 16'(coll_cnt);
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        lookup_result_t e, g;
        if (!aresetn) begin
            mode = MODE_LINEAR;
            tsize = 10'd509;
            klen = 0;
            ksum = 0;
            ovf_next = 0;
            coll_cnt = 0;
            for (int i = 0; i < SLOTS; i++) used[i] = 1'b0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                g.found      = m_tdata[0];
                g.value      = m_tdata[16:1];
                g.slot       = m_tdata[26:17];
                g.probes     = m_tdata[36:27];
                g.home_coll  = m_tdata[37];
                g.full       = m_tdata[38];
                g.coll_total = m_tdata[54:39];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result item", 1, 0);
                end else begin
                    e = expected_results.pop_front();
                    if (g.found != e.found) report_mismatch("found", g.found, e.found);
                    if (g.value != e.value) report_mismatch("result_value", g.value, e.value);
                    if (g.slot != e.slot) report_mismatch("slot_index", g.slot, e.slot);
                    if (g.probes != e.probes)
                        report_mismatch("probe_count", g.probes, e.probes);
                    if (g.home_coll != e.home_coll)
                        report_mismatch("home_collision", g.home_coll, e.home_coll);
                    if (g.full != e.full) report_mismatch("table_full", g.full, e.full);
                    if (g.coll_total != e.coll_total)
                        report_mismatch("collision_total", g.coll_total, e.coll_total);
                end
            end
            if (s_tvalid && s_tready)
                hash_step(s_tuser, s_tdata[7:0], s_tlast, s_tdata[23:8]);
            if (cfg_wr_en) begin
                if (cfg_index == CFG_MODE) mode = cfg_wdata[1:0];
                else tsize = cfg_wdata;
            end
        end
    end
endmodule

>>> verif/hash_table_collision_resolver_tb.sv
`timescale 1ns / 1ps
module hash_table_collision_resolver_tb;
    import hcr_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;
    localparam int POOL = 16;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // key_byte[7:0], value_handle[23:8]
    logic [1:0]       s_tuser;   // operation[1:0]
    logic             s_tlast;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // found, result_value, slot_index, probe_count,
                                 // home_collision, table_full, collision_total
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    int               pending, errors;
    longint           cycles;
    int               items_sent;
    bit               quiet;

    int               pool_len[POOL];
    logic [7:0]       pool_key[POOL][40];
    logic [7:0]       key_bytes[40];

    hash_table_collision_resolver dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_index, .cfg_wdata
    );

    hash_table_checker chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .pending, .errors
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL hash_table_collision_resolver");
            $finish;
        end
    end

    function automatic int gap_len();
        if (quiet) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            m_tready <= (gap_len() == 0);
        end
    end

    task automatic send_byte(logic [1:0] op, logic [7:0] kb, logic last);
        int g;
        @(negedge aclk);
        s_tvalid <= 1;
        s_tdata  <= {16'($urandom), kb};
        s_tuser  <= last ? op : 2'($urandom);
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        g = gap_len();
        @(negedge aclk);
        s_tvalid <= 0;
        repeat (g) @(negedge aclk);
    endtask

    task automatic send_key(logic [1:0] op, int len);
        for (int i = 0; i < len; i++) send_byte(op, key_bytes[i], i == len - 1);
    endtask

    task automatic make_key(output int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 3);
        else if (r < 96) len = $urandom_range(4, 8);
        else len = $urandom_range(30, 40);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 4))
                0: key_bytes[i] = 8'h00;
                1: key_bytes[i] = 8'hFF;
                2: key_bytes[i] = 8'($urandom_range(1, 4));
                default: key_bytes[i] = 8'($urandom);
            endcase
        end
    endtask

    task automatic write_cfg(logic idx, logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    task automatic directed_key(logic [1:0] op, int len, logic [7:0] b0, logic [7:0] b1);
        for (int i = 0; i < len; i++) key_bytes[i] = (i % 2) ? b1 : b0;
        send_key(op, len);
    endtask

    initial begin
        int len, p, cmds, r;
        logic [1:0] op;
        s_tvalid = 0; s_tdata = '0; s_tuser = '0; s_tlast = 0;
        cfg_wr_en = 0; cfg_index = CFG_MODE; cfg_wdata = '0;
        items_sent = 0;
        quiet = 0;
        aresetn = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // reset settings: linear probing, size 509
        directed_key(OP_INSERT, 1, 8'h41, 8'h00);
        directed_key(OP_LOOKUP, 1, 8'h41, 8'h00);
        directed_key(OP_LOOKUP, 1, 8'h42, 8'h00);
        directed_key(OP_INSERT, 2, 8'h00, 8'hFF);
        directed_key(OP_INSERT, 2, 8'h00, 8'hFF);
        directed_key(OP_LOOKUP, 2, 8'h00, 8'hFF);
        directed_key(OP_DISCARD, 1, 8'h41, 8'h00);
        directed_key(OP_CLEAR, 1, 8'h00, 8'h00);
        directed_key(OP_LOOKUP, 1, 8'h41, 8'h00);
        drain();
        write_cfg(CFG_MODE, CFG_W'(MODE_CHAIN));
        write_cfg(CFG_SIZE, 10'd0);
        directed_key(OP_INSERT, 1, 8'h02, 8'h00);
        directed_key(OP_INSERT, 1, 8'h04, 8'h00);
        directed_key(OP_INSERT, 1, 8'h06, 8'h00);
        directed_key(OP_INSERT, 1, 8'h08, 8'h00);
        directed_key(OP_LOOKUP, 1, 8'h04, 8'h00);
        directed_key(OP_LOOKUP, 1, 8'h0A, 8'h00);
        for (int i = 0; i < 38; i++) key_bytes[i] = 8'(i * 37);
        send_key(OP_INSERT, 38);
        send_key(OP_LOOKUP, 38);
        drain();

        for (int i = 0; i < POOL; i++) begin
            pool_len[i] = 1;
            pool_key[i][0] = 8'(i);
        end

        while (items_sent < 1750) begin
            write_cfg(CFG_MODE, CFG_W'($urandom_range(0, 3)));
            r = $urandom_range(0, 19);
            case (r)
                0: write_cfg(CFG_SIZE, 10'd512);
                1: write_cfg(CFG_SIZE, 10'd1023);
                2: write_cfg(CFG_SIZE, 10'd509);
                3: write_cfg(CFG_SIZE, 10'd1);
                4: write_cfg(CFG_SIZE, 10'd2);
                5: write_cfg(CFG_SIZE, 10'($urandom));
                default: write_cfg(CFG_SIZE, 10'($urandom_range(2, 17)));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                make_key(len);
                send_key(OP_CLEAR, len);
            end
            cmds = $urandom_range(10, 40);
            for (int c = 0; c < cmds; c++) begin
                r = $urandom_range(0, 99);
                if (r < 45) op = OP_INSERT;
                else if (r < 90) op = OP_LOOKUP;
                else if (r < 95) op = OP_DISCARD;
                else op = OP_CLEAR;
                p = $urandom_range(0, POOL - 1);
                if ($urandom_range(0, 9) < 7) begin
                    len = pool_len[p];
                    for (int i = 0; i < len; i++) key_bytes[i] = pool_key[p][i];
                end else begin
                    make_key(len);
                    pool_len[p] = len;
                    for (int i = 0; i < len; i++) pool_key[p][i] = key_bytes[i];
                end
                send_key(op, len);
            end
            drain();
        end

        @(negedge aclk);
        s_tvalid <= 0;
        drain();
        if (errors == 0) $display("PASS hash_table_collision_resolver");
        else $display("FAIL hash_table_collision_resolver");
        $finish;
    end
endmodule
